@@ src/e2qr_pkg.sv @@
// ----------------------------------------------------------------------------
// e2qr_pkg
// Shared constants, types and the arctangent table for the Euler to
// quaternion rate block.
// ----------------------------------------------------------------------------
package e2qr_pkg;

  // quotient bits produced by the rate divider
  localparam int QUO_W = 24;

  // CORDIC constants, Q.30 radians
  localparam logic signed [35:0] HALF_PI_Q30   = 36'sd1686629713;
  localparam logic signed [35:0] PI_Q30        = 36'sd3373259426;
  localparam logic signed [33:0] CORDIC_START  = 34'sd652032874;

  // divider status back to the sequencer
  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_res_t;

  // atan(2^-i) in Q.30
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd843314857;
      5'd1:    v = 32'd497837829;
      5'd2:    v = 32'd263043837;
      5'd3:    v = 32'd133525159;
      5'd4:    v = 32'd67021687;
      5'd5:    v = 32'd33543516;
      5'd6:    v = 32'd16775851;
      5'd7:    v = 32'd8388437;
      5'd8:    v = 32'd4194283;
      5'd9:    v = 32'd2097149;
      5'd10:   v = 32'd1048576;
      5'd11:   v = 32'd524288;
      5'd12:   v = 32'd262144;
      5'd13:   v = 32'd131072;
      5'd14:   v = 32'd65536;
      5'd15:   v = 32'd32768;
      5'd16:   v = 32'd16384;
      5'd17:   v = 32'd8192;
      5'd18:   v = 32'd4096;
      5'd19:   v = 32'd2048;
      5'd20:   v = 32'd1024;
      5'd21:   v = 32'd512;
      5'd22:   v = 32'd256;
      5'd23:   v = 32'd128;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

@@ src/e2qr_if.sv @@
// ----------------------------------------------------------------------------
// e2qr channel interfaces
// Sample and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface e2qr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle_x;
  logic signed [15:0] angle_y;
  logic signed [15:0] angle_z;
  logic        [19:0] step_time;

  modport source (output valid, angle_x, angle_y, angle_z, step_time, input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, step_time, output ready);
endinterface

interface e2qr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [23:0] rate_x;
  logic signed [23:0] rate_y;
  logic signed [23:0] rate_z;
  logic               zero_step_flag;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, rate_x, rate_y, rate_z,
                  zero_step_flag, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, rate_x, rate_y, rate_z,
                  zero_step_flag, output ready);
endinterface

@@ src/euler_to_quaternion_rate_top.sv @@
// ----------------------------------------------------------------------------
// euler_to_quaternion_rate_top
// Euler angles to orientation quaternion and body angular rate, built on a
// shared CORDIC stage, one shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  ---------+-----+------------------------------------------------------
//  sample   | in  | angle_x, angle_y, angle_z, step_time
//  result   | out | quat_w/x/y/z, rate_x/y/z, zero_step_flag
//
// One request runs three CORDIC passes of CORDIC_ITERATIONS iterations each,
// the multiplier program on the shared multiplier and three divider runs,
// one for each rate axis.
// Sample ready is high only while the sequencer is idle.
// A finished result waits in the output register; a stalled result only
// holds the sequencer at the end of the next request.
// Reset (synchronous) clears control and the stored previous quaternion.
module euler_to_quaternion_rate_top #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int QUAT_FRAC_BITS    = 14
) (
  input  logic       clk,
  input  logic       rst,
  e2qr_in_if.sink    sample,
  e2qr_out_if.source result
);

  localparam int IT_W  = $clog2(CORDIC_ITERATIONS);
  localparam int SH    = 60 - QUAT_FRAC_BITS;
  localparam int M_W   = 51;
  localparam int DSHF  = 2 * QUAT_FRAC_BITS - 19;
  localparam int DEN_W = 20 + DSHF;
  localparam int NUM_W = ((M_W > DEN_W) ? M_W : DEN_W) + 1;
  localparam logic [4:0] LAST_STEP = 5'd28;

  typedef enum logic [2:0] {
    S_IDLE, S_CLOAD, S_CITER, S_MUL, S_DSTART, S_DWAIT, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    K_NONE, K_P, K_INIT, K_NINIT, K_ADD, K_SUB, K_ADDQ, K_SUBQ, K_ADDN, K_SUBN, K_M
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] idx;
  } op_t;

  state_t state;

  // latched request
  logic signed [15:0] ang [3];
  logic        [19:0] t;

  // cordic
  logic signed [33:0] cx, cy;
  logic signed [35:0] cz;
  logic               flip;
  logic [1:0]         ax;
  logic [IT_W-1:0]    it;

  // intermediate values
  logic signed [31:0] cv [3];
  logic signed [31:0] sv [3];
  logic signed [31:0] p  [4];
  logic signed [15:0] q  [4];
  logic signed [15:0] prev [4];
  logic signed [35:0] n  [3];
  logic signed [M_W-1:0] m [3];
  logic signed [23:0] rate [3];

  // multiplier pipe
  logic [4:0]         step;
  op_t                op, op_d;
  logic signed [35:0] op_a;
  logic signed [31:0] op_b;
  logic signed [67:0] prod, acc;
  logic signed [67:0] base, sum, rq;

  // divider
  logic [1:0]          dx;
  logic                div_start;
  logic [NUM_W-1:0]    div_num;
  logic [DEN_W-1:0]    div_den;
  logic [M_W-1:0]      mag;
  e2qr_pkg::div_res_t  div_res;
  logic signed [23:0]  rate_val;

  // output register
  logic               out_valid;
  logic signed [15:0] oq [4];
  logic signed [23:0] orate [3];
  logic               oflag;

  logic signed [16:0] dq [4];

  // rounding to the quaternion format with saturation
  function automatic logic signed [15:0] to_quat(input logic signed [67:0] v);
    logic signed [67:0] r;
    r = (v + (68'sd1 <<< (SH - 1))) >>> SH;
    if (r > 68'sd32767) begin
      return 16'sh7fff;
    end else if (r < -68'sd32768) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

  // difference to the previous quaternion
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dq[k] = 17'(q[k]) - 17'(prev[k]);
    end
  end

  // cordic step and half-angle range reduction
  logic signed [35:0] h, hr;
  logic               hflip;
  logic signed [33:0] xs, ys, xn, yn, xf, yf;
  logic signed [35:0] zn, atn;

  always_comb begin
    h     = {{3{ang[ax][15]}}, ang[ax], 17'b0};
    hr    = h;
    hflip = 1'b0;
    if (h > e2qr_pkg::HALF_PI_Q30) begin
      hr    = h - e2qr_pkg::PI_Q30;
      hflip = 1'b1;
    end else if (h < -e2qr_pkg::HALF_PI_Q30) begin
      hr    = h + e2qr_pkg::PI_Q30;
      hflip = 1'b1;
    end
    xs  = cx >>> it;
    ys  = cy >>> it;
    atn = {4'b0, e2qr_pkg::atan_q30(5'(it))};
    if (!cz[35]) begin
      xn = cx - ys;
      yn = cy + xs;
      zn = cz - atn;
    end else begin
      xn = cx + ys;
      yn = cy - xs;
      zn = cz + atn;
    end
    xf = flip ? -xn : xn;
    yf = flip ? -yn : yn;
  end

  // multiplier program
  always_comb begin
    op_a    = '0;
    op_b    = '0;
    op.kind = K_NONE;
    op.idx  = 2'd0;
    case (step)
      5'd0:  begin op_a = 36'(cv[0]); op_b = cv[1]; op.kind = K_P;    op.idx = 2'd0; end
      5'd1:  begin op_a = 36'(sv[0]); op_b = sv[1]; op.kind = K_P;    op.idx = 2'd1; end
      5'd2:  begin op_a = 36'(cv[0]); op_b = sv[1]; op.kind = K_P;    op.idx = 2'd2; end
      5'd3:  begin op_a = 36'(sv[0]); op_b = cv[1]; op.kind = K_P;    op.idx = 2'd3; end
      5'd4:  begin op_a = 36'(p[0]);  op_b = cv[2]; op.kind = K_INIT;                end
      5'd5:  begin op_a = 36'(p[1]);  op_b = sv[2]; op.kind = K_SUBQ; op.idx = 2'd0; end
      5'd6:  begin op_a = 36'(p[2]);  op_b = sv[2]; op.kind = K_INIT;                end
      5'd7:  begin op_a = 36'(p[3]);  op_b = cv[2]; op.kind = K_ADDQ; op.idx = 2'd1; end
      5'd8:  begin op_a = 36'(p[2]);  op_b = cv[2]; op.kind = K_INIT;                end
      5'd9:  begin op_a = 36'(p[3]);  op_b = sv[2]; op.kind = K_SUBQ; op.idx = 2'd2; end
      5'd10: begin op_a = 36'(p[0]);  op_b = sv[2]; op.kind = K_INIT;                end
      5'd11: begin op_a = 36'(p[1]);  op_b = cv[2]; op.kind = K_ADDQ; op.idx = 2'd3; end
      5'd13: begin op_a = 36'(dq[0]); op_b = 32'(q[1]); op.kind = K_NINIT;           end
      5'd14: begin op_a = 36'(dq[1]); op_b = 32'(q[0]); op.kind = K_ADD;             end
      5'd15: begin op_a = 36'(dq[2]); op_b = 32'(q[3]); op.kind = K_ADD;             end
      5'd16: begin op_a = 36'(dq[3]); op_b = 32'(q[2]); op.kind = K_SUBN; op.idx = 2'd0; end
      5'd17: begin op_a = 36'(dq[0]); op_b = 32'(q[2]); op.kind = K_NINIT;           end
      5'd18: begin op_a = 36'(dq[1]); op_b = 32'(q[3]); op.kind = K_SUB;             end
      5'd19: begin op_a = 36'(dq[2]); op_b = 32'(q[0]); op.kind = K_ADD;             end
      5'd20: begin op_a = 36'(dq[3]); op_b = 32'(q[1]); op.kind = K_ADDN; op.idx = 2'd1; end
      5'd21: begin op_a = 36'(dq[0]); op_b = 32'(q[3]); op.kind = K_NINIT;           end
      5'd22: begin op_a = 36'(dq[1]); op_b = 32'(q[2]); op.kind = K_ADD;             end
      5'd23: begin op_a = 36'(dq[2]); op_b = 32'(q[1]); op.kind = K_SUB;             end
      5'd24: begin op_a = 36'(dq[3]); op_b = 32'(q[0]); op.kind = K_ADDN; op.idx = 2'd2; end
      5'd25: begin op_a = n[0]; op_b = 32'sd15625; op.kind = K_M; op.idx = 2'd0; end
      5'd26: begin op_a = n[1]; op_b = 32'sd15625; op.kind = K_M; op.idx = 2'd1; end
      5'd27: begin op_a = n[2]; op_b = 32'sd15625; op.kind = K_M; op.idx = 2'd2; end
      default: begin end
    endcase
  end

  // accumulate path of the registered product
  always_comb begin
    base = (op_d.kind == K_INIT || op_d.kind == K_NINIT) ? 68'sd0 : acc;
    if (op_d.kind == K_NINIT || op_d.kind == K_SUB || op_d.kind == K_SUBQ ||
        op_d.kind == K_SUBN) begin
      sum = base - prod;
    end else begin
      sum = base + prod;
    end
    rq = (prod + (68'sd1 <<< 29)) >>> 30;
  end

  // divider operands and saturated rate
  always_comb begin
    mag       = m[dx][M_W-1] ? M_W'(-m[dx]) : M_W'(m[dx]);
    div_den   = {t, {DSHF{1'b0}}};
    div_num   = NUM_W'(mag) + NUM_W'(div_den >> 1);
    div_start = (state == S_DSTART);
    if (t == '0) begin
      rate_val = '0;
    end else if (!m[dx][M_W-1]) begin
      rate_val = (div_res.ovf || div_res.quo > 24'd8388607) ? 24'sh7fffff
                                                            : $signed(div_res.quo);
    end else begin
      rate_val = (div_res.ovf || div_res.quo > 24'd8388608) ? 24'sh800000
                                                            : $signed(-div_res.quo);
    end
  end

  e2qr_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .res   (div_res)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      op_d.kind <= K_NONE;
      op_d.idx  <= 2'd0;
      step      <= '0;
      ax        <= '0;
      dx        <= '0;
      for (int k = 0; k < 4; k++) begin
        prev[k] <= '0;
      end
    end else begin
      // shared multiplier and write-back
      prod <= op_a * op_b;
      op_d <= (state == S_MUL) ? op : op_t'{kind: K_NONE, idx: 2'd0};
      case (op_d.kind)
        K_P:                   p[op_d.idx] <= rq[31:0];
        K_INIT, K_NINIT,
        K_ADD, K_SUB:          acc <= sum;
        K_ADDQ, K_SUBQ:        q[op_d.idx] <= to_quat(sum);
        K_ADDN, K_SUBN:        n[op_d.idx] <= sum[35:0];
        K_M:                   m[op_d.idx] <= prod[M_W-1:0];
        default: begin end
      endcase

      // result taken; the done state reloads the register itself
      if (out_valid && result.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            ang[0] <= sample.angle_x;
            ang[1] <= sample.angle_y;
            ang[2] <= sample.angle_z;
            t      <= sample.step_time;
            ax     <= '0;
            state  <= S_CLOAD;
          end
        end
        S_CLOAD: begin
          cx    <= e2qr_pkg::CORDIC_START;
          cy    <= '0;
          cz    <= hr;
          flip  <= hflip;
          it    <= '0;
          state <= S_CITER;
        end
        S_CITER: begin
          cx <= xn;
          cy <= yn;
          cz <= zn;
          it <= it + 1'b1;
          if (it == IT_W'(CORDIC_ITERATIONS - 1)) begin
            cv[ax] <= xf[31:0];
            sv[ax] <= yf[31:0];
            if (ax == 2'd2) begin
              step  <= '0;
              state <= S_MUL;
            end else begin
              ax    <= ax + 1'b1;
              state <= S_CLOAD;
            end
          end
        end
        S_MUL: begin
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            dx    <= '0;
            state <= S_DSTART;
          end
        end
        S_DSTART: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_res.done) begin
            rate[dx] <= rate_val;
            if (dx == 2'd2) begin
              state <= S_DONE;
            end else begin
              dx    <= dx + 1'b1;
              state <= S_DSTART;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            for (int k = 0; k < 4; k++) begin
              oq[k]   <= q[k];
              prev[k] <= q[k];
            end
            for (int k = 0; k < 3; k++) begin
              orate[k] <= rate[k];
            end
            oflag     <= (t == '0);
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sample.ready          = (state == S_IDLE);
  assign result.valid          = out_valid;
  assign result.quat_w         = oq[0];
  assign result.quat_x         = oq[1];
  assign result.quat_y         = oq[2];
  assign result.quat_z         = oq[3];
  assign result.rate_x         = orate[0];
  assign result.rate_y         = orate[1];
  assign result.rate_z         = orate[2];
  assign result.zero_step_flag = oflag;

  // an accepted request closes the sample channel
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> !sample.ready)
    else $error("sample ready stayed high after a request");

  // zero step time gives zero rates
  a_zero_step_rates: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.zero_step_flag |->
      result.rate_x == 24'sd0 && result.rate_y == 24'sd0 && result.rate_z == 24'sd0)
    else $error("nonzero rate with zero step time");

  // divider finishes only while the sequencer waits on it
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == S_DWAIT)
    else $error("divider finished outside the wait state");

endmodule

@@ src/e2qr_div.sv @@
// ----------------------------------------------------------------------------
// e2qr_div
// Restoring unsigned divider, one quotient bit per cycle, with an overflow
// check for quotients that do not fit the quotient width.
// ----------------------------------------------------------------------------
module e2qr_div #(
  parameter int NUM_W = 52,
  parameter int DEN_W = 29
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [NUM_W-1:0]       num,
  input  logic [DEN_W-1:0]       den,
  output e2qr_pkg::div_res_t     res
);

  localparam int QW  = e2qr_pkg::QUO_W;
  localparam int W   = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;
  localparam int CW  = $clog2(QW + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  dsh;
  logic [QW-1:0] qbits;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          ovf;
  logic          done;
  logic          ge;

  assign ge = (rem >= dsh);

  // one compare and subtract per cycle, first step only checks overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= W'(num);
        dsh  <= W'(den) << QW;
      end else if (busy) begin
        dsh <= dsh >> 1;
        if (cnt == '0) begin
          ovf <= ge;
        end else begin
          qbits <= {qbits[QW-2:0], ge};
          if (ge) begin
            rem <= rem - dsh;
          end
        end
        if (cnt == CW'(QW)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  assign res.done = done;
  assign res.ovf  = ovf;
  assign res.quo  = qbits;

endmodule
